>>> sv/atl_pkg.sv
// ----------------------------------------------------------------------------
// atl_pkg: shared types and constants of the assembler token lexer
// Token kinds, lexer modes, keyword table, payload structs.
// ----------------------------------------------------------------------------
package atl_pkg;

  localparam int MAX_TEXT = 32;
  localparam int TW = $clog2(MAX_TEXT);
  localparam int NKW = 49;
  localparam logic [23:0] LINE_MAX = 24'hFFFFFF;

  localparam logic [7:0] CH_LF    = 8'd10;
  localparam logic [7:0] CH_TAB   = 8'd9;
  localparam logic [7:0] CH_AT    = 8'h40;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_QUOTE = 8'h22;

  typedef enum logic [3:0] {
    K_IDENT = 4'd0, K_KEYWORD = 4'd1, K_NUMBER = 4'd2, K_STRING = 4'd3,
    K_PLUS = 4'd4, K_MINUS = 4'd5, K_COMMA = 4'd6, K_LBRACK = 4'd7,
    K_RBRACK = 4'd8, K_COLON = 4'd9, K_END = 4'd10, K_UNKNOWN = 4'd11
  } kind_t;

  typedef enum logic [2:0] {
    M_IDLE, M_IDENT, M_NUM, M_STR, M_COMMENT
  } mode_t;

  typedef enum logic [2:0] {
    S_READY,   // waiting for a character
    S_DECIDE,  // keyword search runs, pick emission
    S_HDR,     // sending the text header
    S_TEXT,    // sending text rows
    S_AFTER,   // sending the follow-up token of the ending character
    S_ENDTOK   // sending the end token
  } state_t;

  typedef struct packed {
    logic [7:0] char_in;
    logic       end_of_file;
  } in_t;

  typedef struct packed {
    logic [3:0]  kind;
    logic [5:0]  keyword_index;
    logic [31:0] number_value;
    logic [5:0]  text_length;
    logic        truncated;
    logic [23:0] line_number;
    logic        is_text;
    logic [7:0]  text_char;
    logic        last;
  } out_t;

  // keyword table, characters packed low byte first, zero padded
  function automatic logic [63:0] kw_text(input logic [5:0] k);
    case (k)
      6'd0:  kw_text = 64'h6C61;         6'd1:  kw_text = 64'h6C63;
      6'd2:  kw_text = 64'h6C64;         6'd3:  kw_text = 64'h6C62;
      6'd4:  kw_text = 64'h6861;         6'd5:  kw_text = 64'h6863;
      6'd6:  kw_text = 64'h6864;         6'd7:  kw_text = 64'h6862;
      6'd8:  kw_text = 64'h786165;       6'd9:  kw_text = 64'h786365;
      6'd10: kw_text = 64'h786465;       6'd11: kw_text = 64'h786265;
      6'd12: kw_text = 64'h707365;       6'd13: kw_text = 64'h706265;
      6'd14: kw_text = 64'h697365;       6'd15: kw_text = 64'h696465;
      6'd16: kw_text = 64'h766F6D;       6'd17: kw_text = 64'h706D63;
      6'd18: kw_text = 64'h627573;       6'd19: kw_text = 64'h646461;
      6'd20: kw_text = 64'h646E61;       6'd21: kw_text = 64'h726F;
      6'd22: kw_text = 64'h61656C;       6'd23: kw_text = 64'h6C6C6163;
      6'd24: kw_text = 64'h746E69;       6'd25: kw_text = 64'h6C756D69;
      6'd26: kw_text = 64'h76696469;     6'd27: kw_text = 64'h67656E69;
      6'd28: kw_text = 64'h636E69;       6'd29: kw_text = 64'h63656469;
      6'd30: kw_text = 64'h706D6A;       6'd31: kw_text = 64'h656A;
      6'd32: kw_text = 64'h656E6A;       6'd33: kw_text = 64'h65746573;
      6'd34: kw_text = 64'h656E746573;   6'd35: kw_text = 64'h67746573;
      6'd36: kw_text = 64'h6567746573;   6'd37: kw_text = 64'h6C746573;
      6'd38: kw_text = 64'h656C746573;   6'd39: kw_text = 64'h68737570;
      6'd40: kw_text = 64'h706F70;       6'd41: kw_text = 64'h746572;
      6'd42: kw_text = 64'h6E6F6974636573; 6'd43: kw_text = 64'h6C61626F6C67;
      6'd44: kw_text = 64'h757165;       6'd45: kw_text = 64'h73656D6974;
      6'd46: kw_text = 64'h6264;         6'd47: kw_text = 64'h7764;
      6'd48: kw_text = 64'h6464;
      default: kw_text = 64'h0;
    endcase
  endfunction

  function automatic logic [3:0] kw_len(input logic [5:0] k);
    logic [63:0] t;
    logic [3:0]  n;
    t = kw_text(k);
    n = 4'd0;
    for (int i = 0; i < 8; i++) begin
      if (t[8*i +: 8] != 8'h00) n = 4'(i + 1);
    end
    kw_len = n;
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    is_alpha = (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) ||
               c == 8'h5F || c == CH_AT || c == 8'h2E;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    is_digit = c >= 8'h30 && c <= 8'h39;
  endfunction

  // control commands from the controller to the datapath
  typedef struct packed {
    logic       latch;      // capture accepted character and update state
    logic       kw_clear;   // restart the keyword search
    logic       kw_step;    // compare one keyword
    logic       idx_clear;  // reset text read index
    logic       idx_step;   // advance text read index
    logic       out_load;   // load output register
    logic [2:0] sel;        // which row to build
    logic       set_last;
  } cmd_t;

  localparam logic [2:0] SEL_HDR   = 3'd0;
  localparam logic [2:0] SEL_TEXT  = 3'd1;
  localparam logic [2:0] SEL_KW    = 3'd2;
  localparam logic [2:0] SEL_NUM   = 3'd3;
  localparam logic [2:0] SEL_AFTER = 3'd4;
  localparam logic [2:0] SEL_END   = 3'd5;

  typedef struct packed {
    logic       finished;
    logic       eof;
    logic       flush_ident;  // pending identifier emission
    logic       flush_num;
    logic       flush_str;
    logic       after_tok;    // ending char yields a single-row token
    logic       kw_done;
    logic       kw_hit;
    logic       text_empty;
    logic       idx_last;
  } sts_t;

endpackage

>>> sv/assembler_token_lexer_core.sv
// ----------------------------------------------------------------------------
// assembler_token_lexer_core: x86 assembly lexer, one character per request
// Numbers and keywords are sent from the decide state; identifiers and
// strings pass the header and text states, single-row tokens the follow-up
// state, the end token the end state. Keywords and identifiers wait for
// the search, skipped past 8 characters or on truncation. A new request is
// taken only after all rows of the last one are loaded, stalls included.
// Reset (rst_n low, synchronous): idle mode, line 1, no result pending.
// ----------------------------------------------------------------------------
module assembler_token_lexer_core import atl_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  cmd_t cmd;
  sts_t sts;

  atl_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .sts(sts), .cmd(cmd)
  );

  atl_datapath u_dp (
    .clk(clk), .rst_n(rst_n), .in_data(in_data), .cmd(cmd), .sts(sts),
    .out_row(out_data)
  );

endmodule

>>> sv/atl_datapath.sv
// ----------------------------------------------------------------------------
// atl_datapath: lexer state, text buffer, keyword search and result building
// Acts on commands from the controller and reports status.
// ----------------------------------------------------------------------------
module atl_datapath import atl_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  in_t   in_data,
  input  cmd_t  cmd,
  output sts_t  sts,
  output out_t  out_row
);

  logic [7:0]  buf_mem [MAX_TEXT];
  mode_t       mode_r, mode_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        ovf_r, ovf_nxt;
  logic [31:0] acc_r, acc_nxt;
  logic [23:0] line_r, line_nxt;
  logic        fin_r, fin_nxt;
  // snapshot of the pending token, taken at latch
  logic [5:0]  hcnt_r;
  logic        hovf_r;
  logic [31:0] hacc_r;
  logic [23:0] hline_r;
  logic [7:0]  ch_r;
  logic        eof_r;
  logic        fi_r, fi_nxt, fn_r, fn_nxt, fs_r, fs_nxt, at_r, at_nxt;
  kind_t       at_kind_r, at_kind_nxt;
  logic [5:0]  kw_r;
  logic        kw_hit_r;
  logic [5:0]  idx_r;
  logic [7:0]  rd_r;
  logic [63:0] pre_r;   // first eight text characters, for the keyword search
  logic        wr_en;
  logic [TW-1:0] wr_addr;
  logic [63:0] kt;
  logic        kmatch;
  logic [7:0]  c;
  out_t        row_nxt;

  assign c = in_data.char_in;

  // classify a character seen in idle mode
  function automatic void idle_lex(input logic [7:0] ch, output mode_t m,
                                   output logic tok, output kind_t k,
                                   output logic start_txt, output logic push);
    m = M_IDLE; tok = 1'b0; k = K_UNKNOWN; start_txt = 1'b0; push = 1'b0;
    if (ch == 8'h20 || ch == CH_LF || ch == CH_TAB) begin
      m = M_IDLE;
    end else if (is_alpha(ch)) begin
      m = M_IDENT; start_txt = 1'b1; push = 1'b1;
    end else if (is_digit(ch)) begin
      m = M_NUM;
    end else if (ch == CH_QUOTE) begin
      m = M_STR; start_txt = 1'b1;
    end else if (ch == CH_SEMI || ch == CH_HASH) begin
      m = M_COMMENT;
    end else begin
      tok = 1'b1;
      case (ch)
        8'h2B:   k = K_PLUS;
        8'h2D:   k = K_MINUS;
        8'h2C:   k = K_COMMA;
        8'h5B:   k = K_LBRACK;
        8'h5D:   k = K_RBRACK;
        8'h3A:   k = K_COLON;
        default: k = K_UNKNOWN;
      endcase
    end
  endfunction

  always_comb begin
    mode_t m;
    logic  tok, st, ps, do_idle;
    kind_t k;
    mode_nxt = mode_r; cnt_nxt = cnt_r; ovf_nxt = ovf_r; acc_nxt = acc_r;
    line_nxt = line_r; fin_nxt = fin_r;
    fi_nxt = 1'b0; fn_nxt = 1'b0; fs_nxt = 1'b0; at_nxt = 1'b0;
    at_kind_nxt = K_UNKNOWN;
    wr_en = 1'b0; wr_addr = cnt_r[TW-1:0];
    m = M_IDLE; tok = 1'b0; k = K_UNKNOWN; st = 1'b0; ps = 1'b0;
    do_idle = 1'b0;
    if (!fin_r) begin
      if (in_data.end_of_file) begin
        fi_nxt = (mode_r == M_IDENT);
        fn_nxt = (mode_r == M_NUM);
        mode_nxt = M_IDLE;
        fin_nxt = 1'b1;
      end else begin
        case (mode_r)
          M_IDENT: begin
            if (is_alpha(c) || is_digit(c)) ps = 1'b1;
            else begin fi_nxt = 1'b1; do_idle = 1'b1; end
          end
          M_NUM: begin
            if (is_digit(c)) acc_nxt = (acc_r << 3) + (acc_r << 1) + {24'd0, c - 8'h30};
            else begin fn_nxt = 1'b1; do_idle = 1'b1; end
          end
          M_STR: begin
            if (c == CH_QUOTE) begin fs_nxt = 1'b1; mode_nxt = M_IDLE; end
            else ps = 1'b1;
          end
          M_COMMENT: begin
            if (c == CH_LF) mode_nxt = M_IDLE;
          end
          default: do_idle = 1'b1;
        endcase
        if (do_idle) begin
          idle_lex(c, m, tok, k, st, ps);
          mode_nxt = m;
          at_nxt = tok;
          at_kind_nxt = k;
          if (m == M_NUM) acc_nxt = {24'd0, c - 8'h30};
          if (st) begin cnt_nxt = 6'd0; ovf_nxt = 1'b0; end
        end
        if (ps) begin
          if ((st ? 6'd0 : cnt_r) < 6'(MAX_TEXT)) begin
            wr_en = 1'b1;
            wr_addr = st ? '0 : cnt_r[TW-1:0];
            cnt_nxt = (st ? 6'd0 : cnt_r) + 6'd1;
          end else begin
            ovf_nxt = 1'b1;
          end
        end
        if (c == CH_LF && line_r < LINE_MAX) line_nxt = line_r + 24'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_IDLE; cnt_r <= 6'd0; ovf_r <= 1'b0; acc_r <= 32'd0;
      line_r <= 24'd1; fin_r <= 1'b0;
    end else if (cmd.latch) begin
      mode_r <= mode_nxt; cnt_r <= cnt_nxt; ovf_r <= ovf_nxt; acc_r <= acc_nxt;
      line_r <= line_nxt; fin_r <= fin_nxt;
    end
  end

  // snapshot of the token being closed, with the old line
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      hcnt_r <= cnt_r; hovf_r <= ovf_r; hacc_r <= acc_r; hline_r <= line_r;
      ch_r <= c; eof_r <= in_data.end_of_file;
      fi_r <= fi_nxt; fn_r <= fn_nxt; fs_r <= fs_nxt; at_r <= at_nxt;
      at_kind_r <= at_kind_nxt;
    end
  end

  // text buffer: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.latch && wr_en) begin
      buf_mem[wr_addr] <= c;
      if (int'(wr_addr) < 8) pre_r[8*wr_addr[2:0] +: 8] <= c;
    end
    if (cmd.idx_step) rd_r <= buf_mem[idx_r[TW-1:0]];
  end

  // one keyword compared per cycle
  assign kt = kw_text(kw_r);
  always_comb begin
    kmatch = !hovf_r && ({2'b0, kw_len(kw_r)} == hcnt_r);
    for (int i = 0; i < 8; i++) begin
      if (i < int'(hcnt_r) && pre_r[8*i +: 8] != kt[8*i +: 8]) kmatch = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.kw_clear) begin
      kw_r <= 6'd0; kw_hit_r <= 1'b0;
    end else if (cmd.kw_step && !kw_hit_r && kw_r < 6'(NKW)) begin
      if (kmatch) kw_hit_r <= 1'b1;
      else kw_r <= kw_r + 6'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.idx_clear) idx_r <= 6'd0;
    else if (cmd.idx_step) idx_r <= idx_r + 6'd1;
  end

  assign sts.finished    = fin_r;
  assign sts.eof         = eof_r;
  assign sts.flush_ident = fi_r;
  assign sts.flush_num   = fn_r;
  assign sts.flush_str   = fs_r;
  assign sts.after_tok   = at_r;
  assign sts.kw_done     = kw_hit_r || kw_r >= 6'(NKW) || hovf_r || hcnt_r > 6'd8;
  assign sts.kw_hit      = kw_hit_r;
  assign sts.text_empty  = hcnt_r == 6'd0;
  assign sts.idx_last    = idx_r == hcnt_r;

  // result row; every row carries the line before the request
  always_comb begin
    row_nxt = '0;
    row_nxt.line_number = hline_r;
    row_nxt.last = cmd.set_last;
    case (cmd.sel)
      SEL_HDR, SEL_TEXT: begin
        row_nxt.kind = fs_r ? K_STRING : K_IDENT;
        row_nxt.text_length = hcnt_r;
        row_nxt.truncated = hovf_r;
        if (cmd.sel == SEL_TEXT) begin
          row_nxt.is_text = 1'b1;
          row_nxt.text_char = rd_r;
        end
      end
      SEL_KW: begin
        row_nxt.kind = K_KEYWORD;
        row_nxt.keyword_index = kw_r;
      end
      SEL_NUM: begin
        row_nxt.kind = K_NUMBER;
        row_nxt.number_value = hacc_r;
      end
      SEL_AFTER: begin
        row_nxt.kind = at_kind_r;
        if (at_kind_r == K_UNKNOWN) row_nxt.text_char = ch_r;
      end
      default: row_nxt.kind = K_END;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) out_row <= row_nxt;
  end

endmodule

>>> sv/atl_ctrl.sv
// ----------------------------------------------------------------------------
// atl_ctrl: lexer sequencer
// Takes one character, then walks keyword search and result emission.
// ----------------------------------------------------------------------------
module atl_ctrl import atl_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state_r, state_nxt;
  logic   ov_r, ov_nxt;
  logic   fin_seen_r, fin_seen_nxt;
  logic   slot;

  // output register can take a new row
  assign slot = !ov_r || out_ready;
  assign out_valid = ov_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_READY; ov_r <= 1'b0; fin_seen_r <= 1'b0;
    end else begin
      state_r <= state_nxt; ov_r <= ov_nxt;
      fin_seen_r <= fin_seen_nxt;
    end
  end

  always_comb begin
    logic emit;
    logic more_after;
    state_nxt = state_r;
    fin_seen_nxt = fin_seen_r;
    cmd = '0;
    emit = 1'b0;
    in_ready = 1'b0;
    more_after = sts.after_tok || sts.eof;
    case (state_r)
      S_READY: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.latch = 1'b1;
          cmd.kw_clear = 1'b1;
          cmd.idx_clear = 1'b1;
          fin_seen_nxt = sts.finished;
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (fin_seen_r) begin
          state_nxt = S_ENDTOK;
        end else if (sts.flush_ident) begin
          cmd.kw_step = 1'b1;
          if (sts.kw_done) begin
            if (sts.kw_hit) begin
              if (slot) begin
                emit = 1'b1; cmd.sel = SEL_KW; cmd.set_last = !more_after;
                state_nxt = sts.after_tok ? S_AFTER : (sts.eof ? S_ENDTOK : S_READY);
              end
            end else begin
              state_nxt = S_HDR;
            end
          end
        end else if (sts.flush_str) begin
          state_nxt = S_HDR;
        end else if (sts.flush_num) begin
          if (slot) begin
            emit = 1'b1; cmd.sel = SEL_NUM; cmd.set_last = !more_after;
            state_nxt = sts.after_tok ? S_AFTER : (sts.eof ? S_ENDTOK : S_READY);
          end
        end else if (sts.eof) begin
          state_nxt = S_ENDTOK;
        end else if (sts.after_tok) begin
          state_nxt = S_AFTER;
        end else begin
          state_nxt = S_READY;
        end
      end
      S_HDR: begin
        if (slot) begin
          emit = 1'b1; cmd.sel = SEL_HDR;
          cmd.set_last = sts.text_empty && !more_after;
          cmd.idx_step = 1'b1;  // registered read of entry 0 starts
          state_nxt = !sts.text_empty ? S_TEXT :
                      (sts.after_tok ? S_AFTER : (sts.eof ? S_ENDTOK : S_READY));
        end
      end
      S_TEXT: begin
        if (slot) begin
          emit = 1'b1; cmd.sel = SEL_TEXT;
          cmd.set_last = sts.idx_last && !more_after;
          cmd.idx_step = 1'b1;
          if (sts.idx_last)
            state_nxt = sts.after_tok ? S_AFTER : (sts.eof ? S_ENDTOK : S_READY);
        end
      end
      S_AFTER: begin
        if (slot) begin
          emit = 1'b1; cmd.sel = SEL_AFTER; cmd.set_last = 1'b1;
          state_nxt = S_READY;
        end
      end
      S_ENDTOK: begin
        if (slot) begin
          emit = 1'b1; cmd.sel = SEL_END; cmd.set_last = 1'b1;
          state_nxt = S_READY;
        end
      end
      default: state_nxt = S_READY;
    endcase
    cmd.out_load = emit;
    ov_nxt = emit ? 1'b1 : (out_ready ? 1'b0 : ov_r);
  end

endmodule

>>> sv/atl_checker.sv
// ----------------------------------------------------------------------------
// atl_checker: port-level checks of the lexer
// Watches handshakes and result rows over time.
// ----------------------------------------------------------------------------
module atl_checker import atl_pkg::*; (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input in_t  in_data,
  input logic out_valid,
  input logic out_ready,
  input out_t out_data
);

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_data))
    else $error("request changed while waiting");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.kind <= K_UNKNOWN)
    else $error("bad kind");

  a_text_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.is_text |->
      (out_data.kind == K_IDENT || out_data.kind == K_STRING))
    else $error("text row with wrong kind");

  a_one_request: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second request taken before results");

endmodule

bind assembler_token_lexer_core atl_checker u_atl_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
  .in_data(in_data), .out_valid(out_valid), .out_ready(out_ready),
  .out_data(out_data)
);

>>> dv/atl_scoreboard.sv
// ----------------------------------------------------------------------------
// atl_scoreboard: token predictor and result checker for the lexer
// Watches both channels. Every accepted request is run through a local copy
// of the lexing rules; the expected rows are queued and compared field by
// field with the rows the block delivers.
// ----------------------------------------------------------------------------
module atl_scoreboard import atl_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  input  logic in_ready,
  input  in_t  in_data,
  input  logic out_valid,
  input  logic out_ready,
  input  out_t out_data,
  output int   mismatches,
  output int   outstanding,
  output int   rows_checked
);

  localparam string KEYWORDS [NKW] = '{
    "al", "cl", "dl", "bl", "ah", "ch", "dh", "bh",
    "eax", "ecx", "edx", "ebx", "esp", "ebp", "esi", "edi",
    "mov", "cmp", "sub", "add", "and", "or", "lea",
    "call", "int", "imul", "idiv", "ineg", "inc", "idec", "jmp", "je", "jne",
    "sete", "setne", "setg", "setge", "setl", "setle", "push", "pop",
    "ret", "section", "global", "equ", "times", "db", "dw", "dd"
  };

  mode_t       lx_mode;
  logic [7:0]  txt_buf [MAX_TEXT];
  int          txt_cnt;
  logic        txt_ovf;
  logic [31:0] num_acc;
  logic [23:0] cur_line;
  logic        saw_end;
  out_t        token_rows [$];

  function automatic logic word_start(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") ||
           c == "_" || c == "@" || c == ".";
  endfunction

  function automatic logic dec_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  task automatic queue_row(input kind_t k, input logic [5:0] kwi,
                           input logic [31:0] num, input logic [5:0] len,
                           input logic tr, input logic txt, input logic [7:0] ch);
    out_t r;
    r = '0;
    r.kind = k;
    r.keyword_index = kwi;
    r.number_value = num;
    r.text_length = len;
    r.truncated = tr;
    r.line_number = cur_line;
    r.is_text = txt;
    r.text_char = ch;
    token_rows.insert(token_rows.size(), r);
  endtask

  task automatic buffer_char(input logic [7:0] c);
    if (txt_cnt < MAX_TEXT) begin
      txt_buf[txt_cnt] = c;
      txt_cnt++;
    end else begin
      txt_ovf = 1'b1;
    end
  endtask

  function automatic int keyword_of_buffer();
    string s;
    logic  same;
    if (txt_ovf) return -1;
    for (int k = 0; k < NKW; k++) begin
      s = KEYWORDS[k];
      if (s.len() == txt_cnt) begin
        same = 1'b1;
        for (int i = 0; i < txt_cnt; i++) begin
          if (s[i] != txt_buf[i]) same = 1'b0;
        end
        if (same) return k;
      end
    end
    return -1;
  endfunction

  task automatic queue_text(input kind_t k);
    queue_row(k, 6'd0, 32'd0, 6'(txt_cnt), txt_ovf, 1'b0, 8'd0);
    for (int i = 0; i < txt_cnt; i++) begin
      queue_row(k, 6'd0, 32'd0, 6'(txt_cnt), txt_ovf, 1'b1, txt_buf[i]);
    end
  endtask

  task automatic queue_word();
    int k;
    k = keyword_of_buffer();
    if (k >= 0) queue_row(K_KEYWORD, 6'(k), 32'd0, 6'd0, 1'b0, 1'b0, 8'd0);
    else queue_text(K_IDENT);
  endtask

  task automatic begin_token(input logic [7:0] c);
    lx_mode = M_IDLE;
    if (c == " " || c == CH_LF || c == CH_TAB) begin
    end else if (word_start(c)) begin
      lx_mode = M_IDENT;
      txt_cnt = 0;
      txt_ovf = 1'b0;
      buffer_char(c);
    end else if (dec_digit(c)) begin
      lx_mode = M_NUM;
      num_acc = 32'(c - "0");
    end else if (c == CH_QUOTE) begin
      lx_mode = M_STR;
      txt_cnt = 0;
      txt_ovf = 1'b0;
    end else if (c == CH_SEMI || c == CH_HASH) begin
      lx_mode = M_COMMENT;
    end else begin
      case (c)
        "+": queue_row(K_PLUS, 6'd0, 32'd0, 6'd0, 1'b0, 1'b0, 8'd0);
        "-": queue_row(K_MINUS, 6'd0, 32'd0, 6'd0, 1'b0, 1'b0, 8'd0);
        ",": queue_row(K_COMMA, 6'd0, 32'd0, 6'd0, 1'b0, 1'b0, 8'd0);
        "[": queue_row(K_LBRACK, 6'd0, 32'd0, 6'd0, 1'b0, 1'b0, 8'd0);
        "]": queue_row(K_RBRACK, 6'd0, 32'd0, 6'd0, 1'b0, 1'b0, 8'd0);
        ":": queue_row(K_COLON, 6'd0, 32'd0, 6'd0, 1'b0, 1'b0, 8'd0);
        default: queue_row(K_UNKNOWN, 6'd0, 32'd0, 6'd0, 1'b0, 1'b0, c);
      endcase
    end
  endtask

  task automatic lex_request(input in_t req);
    int   before_n;
    logic [7:0] c;
    c = req.char_in;
    before_n = token_rows.size();
    if (saw_end) begin
      queue_row(K_END, 6'd0, 32'd0, 6'd0, 1'b0, 1'b0, 8'd0);
    end else if (req.end_of_file) begin
      if (lx_mode == M_IDENT) queue_word();
      else if (lx_mode == M_NUM) queue_row(K_NUMBER, 6'd0, num_acc, 6'd0, 1'b0, 1'b0, 8'd0);
      queue_row(K_END, 6'd0, 32'd0, 6'd0, 1'b0, 1'b0, 8'd0);
      lx_mode = M_IDLE;
      saw_end = 1'b1;
    end else begin
      case (lx_mode)
        M_IDENT: begin
          if (word_start(c) || dec_digit(c)) buffer_char(c);
          else begin
            queue_word();
            begin_token(c);
          end
        end
        M_NUM: begin
          if (dec_digit(c)) num_acc = num_acc * 32'd10 + 32'(c - "0");
          else begin
            queue_row(K_NUMBER, 6'd0, num_acc, 6'd0, 1'b0, 1'b0, 8'd0);
            begin_token(c);
          end
        end
        M_STR: begin
          if (c == CH_QUOTE) begin
            queue_text(K_STRING);
            lx_mode = M_IDLE;
          end else begin
            buffer_char(c);
          end
        end
        M_COMMENT: begin
          if (c == CH_LF) lx_mode = M_IDLE;
        end
        default: begin_token(c);
      endcase
      // rows caused by the newline itself still carry the old line
      if (c == CH_LF && cur_line != LINE_MAX) cur_line = cur_line + 24'd1;
    end
    if (token_rows.size() > before_n) token_rows[$].last = 1'b1;
  endtask

  task automatic check_row(input out_t got);
    out_t want;
    if (token_rows.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected row %h, nothing pending", got);
      return;
    end
    want = token_rows.pop_front();
    if (got.kind != want.kind || got.keyword_index != want.keyword_index ||
        got.number_value != want.number_value || got.text_length != want.text_length ||
        got.truncated != want.truncated || got.line_number != want.line_number ||
        got.is_text != want.is_text || got.text_char != want.text_char ||
        got.last != want.last) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("row %0d: expected kind=%0d kw=%0d num=%0d len=%0d tr=%0b line=%0d txt=%0b ch=%h last=%0b",
                 rows_checked, want.kind, want.keyword_index, want.number_value,
                 want.text_length, want.truncated, want.line_number, want.is_text,
                 want.text_char, want.last);
        $display("row %0d: actual   kind=%0d kw=%0d num=%0d len=%0d tr=%0b line=%0d txt=%0b ch=%h last=%0b",
                 rows_checked, got.kind, got.keyword_index, got.number_value,
                 got.text_length, got.truncated, got.line_number, got.is_text,
                 got.text_char, got.last);
      end
    end
    rows_checked++;
  endtask

  initial begin
    mismatches = 0;
    outstanding = 0;
    rows_checked = 0;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      lx_mode = M_IDLE;
      txt_cnt = 0;
      txt_ovf = 1'b0;
      num_acc = 32'd0;
      cur_line = 24'd1;
      saw_end = 1'b0;
      token_rows.delete();
    end else begin
      if (in_valid && in_ready) lex_request(in_data);
      if (out_valid && out_ready) check_row(out_data);
    end
    outstanding <= token_rows.size();
  end

endmodule

>>> dv/assembler_token_lexer_core_test.sv
// ----------------------------------------------------------------------------
// assembler_token_lexer_core_test: stimulus and verdict for the lexer
// Feeds directed lines of source, then random token streams (keywords,
// identifiers long and short, numbers that wrap, strings with any byte but the quote,
// comments, punctuation, stray bytes), closes with end of file and a few
// requests after it. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module assembler_token_lexer_core_test;
  import atl_pkg::*;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  in_t  in_data;
  logic out_valid;
  logic out_ready;
  out_t out_data;

  int mismatches;
  int outstanding;
  int rows_checked;
  int chars_sent;
  int calm_send;
  int calm_recv;
  int stall_left;

  assembler_token_lexer_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  atl_scoreboard u_scoreboard (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .mismatches(mismatches), .outstanding(outstanding), .rows_checked(rows_checked)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  initial begin
    #40_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // result side: a random stall before each row, sometimes none at all
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      stall_left <= 0;
      calm_recv <= 0;
    end else if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (out_valid && out_ready) begin
      if ($urandom_range(0, 63) == 0) calm_recv <= (calm_recv == 0) ? 40 : 0;
      else if (calm_recv > 0) calm_recv <= calm_recv - 1;
      if (calm_recv == 0) begin
        stall_left <= $urandom_range(0, 11);
        out_ready <= ($urandom_range(0, 11) == 0);
      end else begin
        out_ready <= 1'b1;
      end
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic put_request(input logic [7:0] c, input logic eof);
    int gap;
    if (calm_send > 0) begin
      gap = 0;
      calm_send--;
    end else begin
      gap = $urandom_range(0, 11);
      if ($urandom_range(0, 31) == 0) calm_send = 20;
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data.char_in <= c;
    in_data.end_of_file <= eof;
    do @(posedge clk); while (!in_ready);
    chars_sent++;
  endtask

  task automatic put_text(input string s);
    for (int i = 0; i < s.len(); i++) put_request(s[i], 1'b0);
  endtask

  function automatic logic [7:0] word_char(input logic first);
    int r;
    r = $urandom_range(0, first ? 54 : 64);
    if (r < 26) return 8'("a" + r);
    if (r < 52) return 8'("A" + r - 26);
    if (r == 52) return "_";
    if (r == 53) return "@";
    if (r == 54) return ".";
    return 8'("0" + r - 55);
  endfunction

  task automatic put_separator();
    case ($urandom_range(0, 5))
      0: put_request(" ", 1'b0);
      1: put_request(CH_TAB, 1'b0);
      2: put_request(CH_LF, 1'b0);
      3: put_request(",", 1'b0);
      4: put_request("]", 1'b0);
      default: put_request(":", 1'b0);
    endcase
  endtask

  task automatic put_random_token();
    logic [63:0] kw;
    logic [5:0]  k;
    logic [7:0]  b;
    int n;
    case ($urandom_range(0, 11))
      0, 1: begin
        k = 6'($urandom_range(0, NKW - 1));
        kw = kw_text(k);
        for (int i = 0; i < kw_len(k); i++) put_request(kw[8*i +: 8], 1'b0);
        put_separator();
      end
      2, 3: begin
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 40) : $urandom_range(1, 8);
        put_request(word_char(1'b1), 1'b0);
        for (int i = 1; i < n; i++) put_request(word_char(1'b0), 1'b0);
        put_separator();
      end
      4: begin
        n = $urandom_range(1, 14);
        for (int i = 0; i < n; i++) put_request(8'("0" + $urandom_range(0, 9)), 1'b0);
        put_separator();
      end
      5: begin
        n = ($urandom_range(0, 7) == 0) ? $urandom_range(32, 36) : $urandom_range(0, 6);
        put_request(CH_QUOTE, 1'b0);
        for (int i = 0; i < n; i++) begin
          b = 8'($urandom_range(0, 255));
          if (b == CH_QUOTE) b = 8'hFF;
          put_request(b, 1'b0);
        end
        put_request(CH_QUOTE, 1'b0);
      end
      6: begin
        put_request($urandom_range(0, 1) ? CH_SEMI : CH_HASH, 1'b0);
        n = $urandom_range(0, 5);
        for (int i = 0; i < n; i++) begin
          b = 8'($urandom_range(0, 255));
          if (b == CH_LF) b = 8'h80;
          put_request(b, 1'b0);
        end
        put_request(CH_LF, 1'b0);
      end
      7: put_text("+-[");
      8: put_request(CH_LF, 1'b0);
      // stray byte, anything at all
      default: put_request(8'($urandom_range(0, 255)), 1'b0);
    endcase
  endtask

  task automatic settle();
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    chars_sent = 0;
    calm_send = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // directed: keywords, number that wraps, string with high bytes,
    // comment, carriage return and punctuation
    put_text("mov [eax],-4294967297:");
    put_request(CH_LF, 1'b0);
    put_text("dd \"a");
    put_request(8'hFF, 1'b0);
    put_request(CH_LF, 1'b0);
    put_text("\";x\n");
    put_request(8'h0D, 1'b0);
    put_text("sections+");

    // make the sender wait for every pending row once
    in_valid <= 1'b0;
    settle();

    while (chars_sent < 110) put_random_token();
    if ($urandom_range(0, 1)) put_text("x1");
    put_request(8'd0, 1'b1);
    put_request(8'h41, 1'b0);
    put_request(8'h00, 1'b1);
    in_valid <= 1'b0;

    settle();
    repeat (200) @(posedge clk);

    $display("lexed %0d source bytes, %0d token rows compared", chars_sent, rows_checked);
    if (mismatches == 0 && outstanding == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

>>> sim.f
sv/atl_pkg.sv
sv/atl_datapath.sv
sv/atl_ctrl.sv
sv/assembler_token_lexer_core.sv
sv/atl_checker.sv
dv/atl_scoreboard.sv
dv/assembler_token_lexer_core_test.sv
